### src/ordered_dither_mono_line_writer_macros.svh
// Assertion macros used by the checker module of the line writer.
`ifndef ORDERED_DITHER_MONO_LINE_WRITER_MACROS_SVH
`define ORDERED_DITHER_MONO_LINE_WRITER_MACROS_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define ODML_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("odml assertion failed");

// Next-cycle implication, sampled on clock, off during reset.
`define ODML_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("odml assertion failed");

`endif

### src/odml_pkg.sv
// Package of the ordered dither mono line writer: sizes, field positions, dither table.
package odml_pkg;

   localparam int LINE_PIXELS = 1024;
   localparam int STORE_BYTES = (LINE_PIXELS + 7) / 8;
   localparam int BYTE_AW     = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;

   // field widths fixed by the stream format
   localparam int X_W     = 10;
   localparam int Y_W     = 10;
   localparam int COLOR_W = 8;
   localparam int WIDTH_W = 11;
   localparam int BG_W    = 32;
   localparam int IDX_W   = 7;

   localparam int REQ_TDATA_W = 48;
   localparam int RSP_TDATA_W = 24;

   // request tdata positions
   localparam int REQ_X_LO = 0;
   localparam int REQ_Y_LO = REQ_X_LO + X_W;
   localparam int REQ_R_LO = REQ_Y_LO + Y_W;
   localparam int REQ_G_LO = REQ_R_LO + COLOR_W;
   localparam int REQ_B_LO = REQ_G_LO + COLOR_W;

   // response tdata positions
   localparam int RSP_IDX_LO  = 0;
   localparam int RSP_VAL_LO  = RSP_IDX_LO + IDX_W;
   localparam int RSP_MONO    = RSP_VAL_LO + 8;
   localparam int RSP_DRAWN   = RSP_MONO + 1;
   localparam int RSP_OVFL    = RSP_DRAWN + 1;
   localparam int RSP_USED_W  = RSP_OVFL + 1;

   // configuration register indexes
   localparam int CSR_IW = 1;
   localparam logic [CSR_IW-1:0] CSR_BACKGROUND_COLOR = 1'd0;
   localparam logic [CSR_IW-1:0] CSR_LINE_WIDTH       = 1'd1;

   localparam logic [WIDTH_W-1:0] LINE_WIDTH_RESET = 11'd1024;

   localparam logic signed [5:0] BAYER_TABLE [4][4] = '{
      '{-6'sd32,  6'sd0,  -6'sd24,  6'sd8},
      '{ 6'sd16, -6'sd16,  6'sd24, -6'sd8},
      '{-6'sd20,  6'sd12, -6'sd28,  6'sd4},
      '{ 6'sd28, -6'sd4,   6'sd20, -6'sd12}
   };

   typedef struct packed {
      logic               en;
      logic [BYTE_AW-1:0] addr;
      logic [7:0]         data;
   } odml_wr_type;

endpackage

### src/odml_dither.sv
// Ordered dither and fast luma threshold for one pixel colour.
module odml_dither (
   input  logic [1:0]                   x_phase,
   input  logic [1:0]                   y_phase,
   input  logic [odml_pkg::COLOR_W-1:0] red,
   input  logic [odml_pkg::COLOR_W-1:0] green,
   input  logic [odml_pkg::COLOR_W-1:0] blue,
   output logic                         mono_bit
);

   logic signed [5:0]  offset;
   logic signed [12:0] dr;
   logic signed [12:0] dg;
   logic signed [12:0] db;
   logic signed [12:0] sum;

   always_comb begin
      offset = odml_pkg::BAYER_TABLE[x_phase][y_phase];
      dr  = $signed({5'b0, red})   + 13'(offset);
      dg  = $signed({5'b0, green}) + 13'(offset);
      db  = $signed({5'b0, blue})  + 13'(offset);
      // 3r + 4g + b, luma >= 128 exactly when the sum reaches 1024
      sum = (dr <<< 1) + dr + (dg <<< 2) + db;
      mono_bit = (sum >= 13'sd1024);
   end

endmodule

### src/odml_line_store.sv
// 1bpp line store: byte RAM with valid bits and write-to-read forwarding.
module odml_line_store (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         rd_en,
   input  logic [odml_pkg::BYTE_AW-1:0] rd_addr,
   input  odml_pkg::odml_wr_type        wr,
   output logic [7:0]                   rd_byte
);

   logic [7:0]                   mem [odml_pkg::STORE_BYTES];
   logic [7:0]                   rdata_ff;
   logic [odml_pkg::BYTE_AW-1:0] rd_addr_ff;
   logic [odml_pkg::STORE_BYTES-1:0] valid_ff;
   logic                         last_en_ff;
   logic [odml_pkg::BYTE_AW-1:0] last_addr_ff;
   logic [7:0]                   last_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      if (rd_en) begin
         rdata_ff   <= mem[rd_addr];
         rd_addr_ff <= rd_addr;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= '0;
         last_en_ff <= 1'b0;
      end else if (wr.en) begin
         valid_ff[wr.addr] <= 1'b1;
         last_en_ff        <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr.en) begin
         last_addr_ff <= wr.addr;
         last_data_ff <= wr.data;
      end
   end

   // the read may have raced the latest write to the same byte: take that write
   always_comb begin
      if (last_en_ff && (last_addr_ff == rd_addr_ff)) begin
         rd_byte = last_data_ff;
      end else if (valid_ff[rd_addr_ff]) begin
         rd_byte = rdata_ff;
      end else begin
         rd_byte = 8'd0;
      end
   end

endmodule

### src/ordered_dither_mono_line_writer.sv
// Top level of the ordered dither mono line writer.
//
// req_ carries one pixel per beat: position, line number, colour in tdata and
// the opaque flag in tuser. rsp_ returns one beat per pixel with the store byte
// it touched, the byte after the update, the dithered bit and drawn/overflow.
// csr_ writes background_color (index 0) and line_width (index 1) only while
// idle: the user must keep to this, as the block itself does not enforce it.
// Pipeline: the accepting edge reads the line store RAM; stage s1 then dithers,
// merges the bit and writes the byte back as the beat moves into the output
// register. rsp_tvalid rises once the beat is in the output register, and one
// pixel is taken every cycle while rsp_tready stays high, limited by
// the single RAM write port. A write that races a following read of the same
// byte is forwarded.
//
// Reset clears the line store through per-byte valid bits at once, sets
// background_color to 0 and line_width to 1024; no clearing pass is needed.
// When rsp_tready is low the output register holds its beat, one more pixel
// waits in the RAM stage, and req_tready then drops.
module ordered_dither_mono_line_writer (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // pixel_x, row_y, red, green, blue, zero fill
   input  logic [odml_pkg::REQ_TDATA_W-1:0]    req_tdata,
   // opaque
   input  logic                                req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // byte_index, byte_value, mono_bit, drawn, overflow, zero fill
   output logic [odml_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   input  logic                                csr_we,
   input  logic [odml_pkg::CSR_IW-1:0]         csr_index,
   input  logic [odml_pkg::BG_W-1:0]           csr_wdata
);

   logic [odml_pkg::BG_W-1:0]    bg_ff;
   logic [odml_pkg::WIDTH_W-1:0] width_ff;

   logic                         accept;
   logic                         s1_adv;
   logic                         s1_valid_ff;
   logic [odml_pkg::X_W-1:0]     s1_x_ff;
   logic [1:0]                   s1_y_ff;
   logic [odml_pkg::COLOR_W-1:0] s1_r_ff;
   logic [odml_pkg::COLOR_W-1:0] s1_g_ff;
   logic [odml_pkg::COLOR_W-1:0] s1_b_ff;
   logic                         s1_opaque_ff;

   logic [odml_pkg::X_W-1:0]     req_x;
   logic [odml_pkg::COLOR_W-1:0] sel_r;
   logic [odml_pkg::COLOR_W-1:0] sel_g;
   logic [odml_pkg::COLOR_W-1:0] sel_b;
   logic                         coloured;
   logic                         dith_bit;
   logic                         in_store;
   logic                         refused;
   logic [7:0]                   cur_byte;
   logic [7:0]                   new_byte;
   logic [7:0]                   out_byte;
   odml_pkg::odml_wr_type        wr;

   logic                             out_valid_ff;
   logic [odml_pkg::RSP_USED_W-1:0]  out_data_ff;
   logic [odml_pkg::RSP_USED_W-1:0]  out_data_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         bg_ff    <= '0;
         width_ff <= odml_pkg::LINE_WIDTH_RESET;
      end else if (csr_we) begin
         case (csr_index)
            odml_pkg::CSR_BACKGROUND_COLOR: bg_ff <= csr_wdata;
            odml_pkg::CSR_LINE_WIDTH: width_ff <= csr_wdata[odml_pkg::WIDTH_W-1:0];
            default: ;
         endcase
      end
   end

   assign s1_adv     = s1_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_adv;
   assign accept     = req_tvalid && req_tready;
   assign req_x      = req_tdata[odml_pkg::REQ_X_LO +: odml_pkg::X_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (accept) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_adv) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_x_ff      <= req_x;
         s1_y_ff      <= req_tdata[odml_pkg::REQ_Y_LO +: 2];
         s1_r_ff      <= req_tdata[odml_pkg::REQ_R_LO +: odml_pkg::COLOR_W];
         s1_g_ff      <= req_tdata[odml_pkg::REQ_G_LO +: odml_pkg::COLOR_W];
         s1_b_ff      <= req_tdata[odml_pkg::REQ_B_LO +: odml_pkg::COLOR_W];
         s1_opaque_ff <= req_tuser;
      end
   end

   odml_line_store u_store (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (accept),
      .rd_addr (odml_pkg::BYTE_AW'(req_x >> 3)),
      .wr      (wr),
      .rd_byte (cur_byte)
   );

   // pick the pixel colour or the background, red in the top byte
   always_comb begin
      if (s1_opaque_ff) begin
         sel_r = s1_r_ff;
         sel_g = s1_g_ff;
         sel_b = s1_b_ff;
      end else begin
         sel_r = bg_ff[31:24];
         sel_g = bg_ff[23:16];
         sel_b = bg_ff[15:8];
      end
      coloured = s1_opaque_ff || (bg_ff != '0);
   end

   odml_dither u_dither (
      .x_phase  (s1_x_ff[1:0]),
      .y_phase  (s1_y_ff),
      .red      (sel_r),
      .green    (sel_g),
      .blue     (sel_b),
      .mono_bit (dith_bit)
   );

   always_comb begin
      in_store = (32'(s1_x_ff) < odml_pkg::LINE_PIXELS);
      refused  = ({1'b0, s1_x_ff} >= width_ff) || !in_store;
      new_byte = cur_byte;
      new_byte[s1_x_ff[2:0]] = coloured && dith_bit;
      wr.en    = s1_adv && coloured && !refused;
      wr.addr  = odml_pkg::BYTE_AW'(s1_x_ff >> 3);
      wr.data  = new_byte;
      if (!in_store) begin
         out_byte = 8'd0;
      end else if (coloured && !refused) begin
         out_byte = new_byte;
      end else begin
         out_byte = cur_byte;
      end
      out_data_in = {refused,
                     coloured && !refused,
                     coloured && dith_bit,
                     out_byte,
                     s1_x_ff[odml_pkg::X_W-1:3]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (s1_adv) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         out_data_ff <= out_data_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = odml_pkg::RSP_TDATA_W'(out_data_ff);

endmodule

### src/odml_checker.sv
// Port-level checker for the line writer, bound to the top level.
`include "ordered_dither_mono_line_writer_macros.svh"

module odml_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tvalid,
   input logic                             req_tready,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [odml_pkg::RSP_TDATA_W-1:0] rsp_tdata
);

   logic mono;
   logic drawn;
   logic ovfl;

   assign mono  = rsp_tdata[odml_pkg::RSP_MONO];
   assign drawn = rsp_tdata[odml_pkg::RSP_DRAWN];
   assign ovfl  = rsp_tdata[odml_pkg::RSP_OVFL];

   // stalled beat holds
   `ODML_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))
   // an accepted pixel must be followed by rsp_tvalid
   `ODML_ASSERT_NOW(a_latency, req_tvalid && req_tready, ##2 rsp_tvalid)
   // a refused position is never drawn
   `ODML_ASSERT_NOW(a_refused_not_drawn, rsp_tvalid && ovfl, !drawn)
   // nothing to draw at a valid position gives a clear bit
   `ODML_ASSERT_NOW(a_clear_bit, rsp_tvalid && !ovfl && !drawn, !mono)

endmodule

bind ordered_dither_mono_line_writer odml_checker u_odml_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
